// File: src/sdk_pkg.sv
`default_nettype none

package sdk_pkg;

   // Opcode carried on the request tuser bit.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // Result status carried on the response tuser bits.
   typedef enum logic [2:0] {
      STAT_APPENDED = 3'd0,
      STAT_REPLACED = 3'd1,
      STAT_DROPPED  = 3'd2,
      STAT_READ_OK  = 3'd3,
      STAT_READ_OOR = 3'd4
   } status_type;

   // One stored entry: Q16.16 delta, Q16.16 unit factor and a tag.
   typedef struct packed {
      logic [31:0] delta;
      logic [31:0] factor;
      logic [15:0] tag;
   } entry_type;

endpackage

`default_nettype wire

// File: src/sdk_entry_store.sv
`default_nettype none

// Entry memory with one write port and one registered read port.
module sdk_entry_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire sdk_pkg::entry_type wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output sdk_pkg::entry_type     rd_data
);

   sdk_pkg::entry_type mem [DEPTH];
   sdk_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/smallest_delta_keeper.sv
`default_nettype none

// Keeps up to a configured number of entries with the smallest deltas.
// Request beats arrive on req_*: tuser is the opcode (insert or read) and
// tdata carries the new entry and the read index. Each request produces
// exactly one response beat on rsp_*, with the status in tuser and the slot,
// the entry read and the count of held entries in tdata. The capacity is set
// through csr_wen/csr_wdata; the user must write it only while the block is
// idle, as the block does not enforce this. It resets to 16. Appends, drops
// with nothing held and out-of-range reads need no wait for the memory read.
// An insert into a full list scans every held entry through the one delta
// comparator fed by the single read port of the entry memory, one entry per
// cycle, and then writes the new entry over the largest delta or drops it.
// The block takes one request at a time: req_tready is high only while the
// sequencer is idle, so a request is taken only after the last has finished.
// A finished response sits in the output register, so a new request is
// accepted while the receiver stalls; that request then waits in its last
// step until the output register is free. Reset empties the list at once
// (the held count goes to zero); memory contents are not cleared.
module smallest_delta_keeper #(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata from bit 0 up: new_delta[31:0], new_factor[63:32], new_tag[79:64],
   // read_index[83:80], zero fill[87:84].
   input  wire logic [87:0] req_tdata,
   // tuser: opcode[0].
   input  wire logic        req_tuser,
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata from bit 0 up: slot[3:0], out_delta[35:4], out_factor[67:36],
   // out_tag[83:68], entry_count[88:84], zero fill[95:89].
   output logic [95:0]      rsp_tdata,
   // tuser: status[2:0].
   output logic [2:0]       rsp_tuser,
   // Capacity register write port.
   input  wire logic        csr_wen,
   input  wire logic [4:0]  csr_wdata
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RDWAIT,
      ST_DONE
   } state_type;

   // Request fields.
   logic [31:0] req_delta;
   logic [31:0] req_factor;
   logic [15:0] req_tag;
   logic [3:0]  req_index;

   assign req_delta  = req_tdata[31:0];
   assign req_factor = req_tdata[63:32];
   assign req_tag    = req_tdata[79:64];
   assign req_index  = req_tdata[83:80];

   // Control registers.
   state_type            state_ff, state_in;
   logic [CW-1:0]        held_ff, held_in;
   logic [4:0]           capacity_ff, capacity_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 iss_done_ff, iss_done_in;
   logic                 cmp_vld_ff, cmp_vld_in;

   // Datapath registers.
   logic [IW-1:0]        iss_ff, iss_in;
   logic [IW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                 cmp_last_ff, cmp_last_in;
   logic [31:0]          best_ff, best_in;
   logic [IW-1:0]        pos_ff, pos_in;
   logic                 found_ff, found_in;
   logic [31:0]          cap_delta_ff, cap_delta_in;
   logic [31:0]          cap_factor_ff, cap_factor_in;
   logic [15:0]          cap_tag_ff, cap_tag_in;
   logic [3:0]           cap_idx_ff, cap_idx_in;
   sdk_pkg::status_type  pend_status_ff, pend_status_in;
   logic [3:0]           pend_slot_ff, pend_slot_in;
   logic [31:0]          pend_delta_ff, pend_delta_in;
   logic [31:0]          pend_factor_ff, pend_factor_in;
   logic [15:0]          pend_tag_ff, pend_tag_in;
   sdk_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [3:0]           rsp_slot_ff, rsp_slot_in;
   logic [31:0]          rsp_delta_ff, rsp_delta_in;
   logic [31:0]          rsp_factor_ff, rsp_factor_in;
   logic [15:0]          rsp_tag_ff, rsp_tag_in;
   logic [4:0]           rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic                 mem_wr_en;
   logic [IW-1:0]        mem_wr_addr;
   sdk_pkg::entry_type   mem_wr_data;
   logic                 mem_rd_en;
   logic [IW-1:0]        mem_rd_addr;
   sdk_pkg::entry_type   mem_rd_data;

   // Scan helpers.
   logic                 upd;
   logic                 found_fin;
   logic [IW-1:0]        pos_fin;
   logic [31:0]          eff_cap;
   logic                 can_append;
   logic                 accept;

   sdk_entry_store #(
      .DEPTH (MAX_ENTRIES),
      .AW    (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // The capacity in force never exceeds the storage depth.
   assign eff_cap    = (32'(capacity_ff) < 32'(MAX_ENTRIES)) ? 32'(capacity_ff)
                                                            : 32'(MAX_ENTRIES);
   assign can_append = (32'(held_ff) < eff_cap);

   // The comparator: a stored delta replaces the running best only when it
   // is strictly larger, so the first of equal largest deltas wins and a
   // stored delta equal to the new one never causes a replacement.
   assign upd       = cmp_vld_ff && (mem_rd_data.delta > best_ff);
   assign found_fin = found_ff || upd;
   assign pos_fin   = upd ? cmp_idx_ff : pos_ff;

   always_comb begin
      state_in       = state_ff;
      held_in        = held_ff;
      capacity_in    = capacity_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      iss_done_in    = iss_done_ff;
      cmp_vld_in     = 1'b0;
      iss_in         = iss_ff;
      cmp_idx_in     = cmp_idx_ff;
      cmp_last_in    = cmp_last_ff;
      best_in        = best_ff;
      pos_in         = pos_ff;
      found_in       = found_ff;
      cap_delta_in   = cap_delta_ff;
      cap_factor_in  = cap_factor_ff;
      cap_tag_in     = cap_tag_ff;
      cap_idx_in     = cap_idx_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      pend_delta_in  = pend_delta_ff;
      pend_factor_in = pend_factor_ff;
      pend_tag_in    = pend_tag_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_delta_in   = rsp_delta_ff;
      rsp_factor_in  = rsp_factor_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_count_in   = rsp_count_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = held_ff[IW-1:0];
      mem_wr_data    = '{delta: req_delta, factor: req_factor, tag: req_tag};
      mem_rd_en      = 1'b0;
      mem_rd_addr    = iss_ff;

      if (csr_wen) begin
         capacity_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cap_delta_in   = req_delta;
               cap_factor_in  = req_factor;
               cap_tag_in     = req_tag;
               cap_idx_in     = req_index;
               pend_slot_in   = 4'd0;
               pend_delta_in  = 32'd0;
               pend_factor_in = 32'd0;
               pend_tag_in    = 16'd0;
               if (req_tuser == sdk_pkg::OP_INSERT) begin
                  priority if (can_append) begin
                     mem_wr_en      = 1'b1;
                     held_in        = held_ff + CW'(1);
                     pend_status_in = sdk_pkg::STAT_APPENDED;
                     pend_slot_in   = 4'(held_ff);
                     state_in       = ST_DONE;
                  end else if (held_ff == '0) begin
                     pend_status_in = sdk_pkg::STAT_DROPPED;
                     state_in       = ST_DONE;
                  end else begin
                     best_in     = req_delta;
                     found_in    = 1'b0;
                     pos_in      = '0;
                     iss_in      = '0;
                     iss_done_in = 1'b0;
                     state_in    = ST_SCAN;
                  end
               end else begin
                  if (32'(req_index) < 32'(held_ff)) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = IW'(req_index);
                     state_in    = ST_RDWAIT;
                  end else begin
                     pend_status_in = sdk_pkg::STAT_READ_OOR;
                     state_in       = ST_DONE;
                  end
               end
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle; its delta is compared in the next cycle.
            if (!iss_done_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = iss_ff;
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = iss_ff;
               cmp_last_in = (32'(iss_ff) + 32'd1 == 32'(held_ff));
               if (32'(iss_ff) + 32'd1 == 32'(held_ff)) begin
                  iss_done_in = 1'b1;
               end else begin
                  iss_in = iss_ff + IW'(1);
               end
            end
            if (upd) begin
               best_in  = mem_rd_data.delta;
               pos_in   = cmp_idx_ff;
               found_in = 1'b1;
            end
            if (cmp_vld_ff && cmp_last_ff) begin
               if (found_fin) begin
                  mem_wr_en      = 1'b1;
                  mem_wr_addr    = pos_fin;
                  mem_wr_data    = '{delta: cap_delta_ff, factor: cap_factor_ff,
                                     tag: cap_tag_ff};
                  pend_status_in = sdk_pkg::STAT_REPLACED;
                  pend_slot_in   = 4'(pos_fin);
               end else begin
                  pend_status_in = sdk_pkg::STAT_DROPPED;
               end
               state_in = ST_DONE;
            end
         end

         ST_RDWAIT: begin
            pend_status_in = sdk_pkg::STAT_READ_OK;
            pend_slot_in   = cap_idx_ff;
            pend_delta_in  = mem_rd_data.delta;
            pend_factor_in = mem_rd_data.factor;
            pend_tag_in    = mem_rd_data.tag;
            state_in       = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_slot_in   = pend_slot_ff;
               rsp_delta_in  = pend_delta_ff;
               rsp_factor_in = pend_factor_ff;
               rsp_tag_in    = pend_tag_ff;
               rsp_count_in  = 5'(held_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         capacity_ff  <= 5'd16;
         rsp_valid_ff <= 1'b0;
         iss_done_ff  <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_done_ff  <= iss_done_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
      iss_ff         <= iss_in;
      cmp_idx_ff     <= cmp_idx_in;
      cmp_last_ff    <= cmp_last_in;
      best_ff        <= best_in;
      pos_ff         <= pos_in;
      found_ff       <= found_in;
      cap_delta_ff   <= cap_delta_in;
      cap_factor_ff  <= cap_factor_in;
      cap_tag_ff     <= cap_tag_in;
      cap_idx_ff     <= cap_idx_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      pend_delta_ff  <= pend_delta_in;
      pend_factor_ff <= pend_factor_in;
      pend_tag_ff    <= pend_tag_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_delta_ff   <= rsp_delta_in;
      rsp_factor_ff  <= rsp_factor_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_tag_ff, rsp_factor_ff,
                        rsp_delta_ff, rsp_slot_ff};

endmodule

`default_nettype wire
